[rtl/core/spb_pkg.sv]
// Shared types and constants for the sparse paged bitmap unit.
package spb_pkg;

  // Fixed field widths of the operation and result transfers.
  localparam int unsigned POS_W   = 32;
  localparam int unsigned COUNT_W = 15;

  // Operation codes carried by in_action.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_PAGE = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the operation, compare tags, read the page word
    logic commit;   // apply the update and register the result
  } dp_cmd_t;

endpackage

[rtl/core/spb_ctrl.sv]
// Controller state machine of the sparse paged bitmap unit.
module spb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output spb_pkg::dp_cmd_t cmd
);

  spb_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Commands follow directly from the state and the start request.
  always_comb begin
    cmd.capture = start && (state_r == spb_pkg::S_IDLE);
    cmd.commit  = (state_r == spb_pkg::S_UPDATE);
  end

  // Two-state sequence: capture in idle, commit in the update cycle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spb_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = spb_pkg::S_UPDATE;
        end
      end
      spb_pkg::S_UPDATE: begin
        state_nxt = spb_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spb_pkg::S_IDLE;
      end
    endcase
  end

  // The result strobe follows the commit cycle.
  assign out_valid_nxt = cmd.commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == spb_pkg::S_UPDATE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/spb_dpath.sv]
// Datapath of the sparse paged bitmap unit: page tags, page word memory and set-bit count.
module spb_dpath #(
  parameter int unsigned PAGE_SLOTS    = 16,
  parameter int unsigned BITS_PER_PAGE = 1024,
  parameter int unsigned BITS_PER_WORD = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spb_pkg::dp_cmd_t              cmd,
  input  logic                          in_action,
  input  logic [spb_pkg::POS_W-1:0]     in_position,
  input  logic                          in_bit_in,
  output logic                          out_bit_out,
  output logic                          out_status,
  output logic [spb_pkg::COUNT_W-1:0]   out_set_count
);

  // Geometry; the user must keep page and word sizes powers of two; the block does not enforce it.
  localparam int unsigned USED_W    = (POSITION_BITS < spb_pkg::POS_W) ?
                                      POSITION_BITS : spb_pkg::POS_W;
  localparam int unsigned PAGE_LOG2 = $clog2(BITS_PER_PAGE);
  localparam int unsigned WORD_W    = (BITS_PER_WORD < BITS_PER_PAGE) ?
                                      BITS_PER_WORD : BITS_PER_PAGE;
  localparam int unsigned WORD_LOG2 = $clog2(WORD_W);
  localparam int unsigned WPP       = BITS_PER_PAGE / WORD_W;
  localparam int unsigned WIDX_W    = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int unsigned SLOT_W    = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int unsigned TAG_W     = POSITION_BITS - PAGE_LOG2;
  localparam int unsigned ADDR_W    = SLOT_W + WIDX_W;
  localparam int unsigned MEM_DEPTH = PAGE_SLOTS << WIDX_W;

  // Stored state.
  logic [TAG_W-1:0]                 tag_r [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0]            valid_r;
  logic [PAGE_SLOTS-1:0][WPP-1:0]   wvalid_r;
  logic [WORD_W-1:0]                mem [MEM_DEPTH];
  logic [spb_pkg::COUNT_W-1:0]      ones_r, ones_nxt;

  // Operation registers, loaded on capture.
  logic                 act_r, val_r, hit_r, free_ok_r;
  logic [TAG_W-1:0]     page_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [WIDX_W-1:0]    widx_r;
  logic [WORD_LOG2-1:0] bidx_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 rd_wvalid_r;

  // Result registers.
  logic bit_out_r, status_r;

  // Split the incoming position into page number, word index and bit index.
  logic [POSITION_BITS-1:0] pos;
  logic [TAG_W-1:0]         page;
  logic [PAGE_LOG2-1:0]     offset;
  logic [WIDX_W-1:0]        widx;
  logic [WORD_LOG2-1:0]     bidx;

  assign pos    = POSITION_BITS'(in_position[USED_W-1:0]);
  assign page   = pos[POSITION_BITS-1:PAGE_LOG2];
  assign offset = pos[PAGE_LOG2-1:0];
  assign widx   = WIDX_W'(offset >> WORD_LOG2);
  assign bidx   = offset[WORD_LOG2-1:0];

  // Parallel tag compare, hit encode and lowest free slot search.
  logic [PAGE_SLOTS-1:0] match;
  logic                  hit, free_ok;
  logic [SLOT_W-1:0]     hit_slot, free_slot, eff_slot;
  logic [ADDR_W-1:0]     raddr;

  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int s = 0; s < PAGE_SLOTS; s++) begin
      match[s] = valid_r[s] && (tag_r[s] == page);
      if (match[s]) begin
        hit_slot = hit_slot | SLOT_W'(s);
      end
    end
    for (int s = PAGE_SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_slot = SLOT_W'(s);
      end
    end
    hit      = |match;
    free_ok  = ~&valid_r;
    eff_slot = hit ? hit_slot : free_slot;
    raddr    = {eff_slot, widx};
  end

  // Capture the operation and read the addressed page word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r       <= in_action;
      val_r       <= in_bit_in;
      page_r      <= page;
      hit_r       <= hit;
      free_ok_r   <= free_ok;
      slot_r      <= eff_slot;
      widx_r      <= widx;
      bidx_r      <= bidx;
      rd_data_r   <= mem[raddr];
      rd_wvalid_r <= wvalid_r[eff_slot][widx];
    end
  end

  // Update decision: old bit, allocation, drop and the new word value.
  logic              old_bit, alloc, no_page, do_wr;
  logic [WORD_W-1:0] base, bit_mask, new_word;

  always_comb begin
    base     = (hit_r && rd_wvalid_r) ? rd_data_r : '0;
    bit_mask = WORD_W'(1) << bidx_r;
    old_bit  = hit_r && rd_wvalid_r && rd_data_r[bidx_r];
    alloc    = (act_r == spb_pkg::ACT_WRITE) && val_r && !hit_r && free_ok_r;
    no_page  = (act_r == spb_pkg::ACT_WRITE) && val_r && !hit_r && !free_ok_r;
    do_wr    = (act_r == spb_pkg::ACT_WRITE) && (hit_r || alloc) && (old_bit != val_r);
    new_word = val_r ? (base | bit_mask) : (base & ~bit_mask);
    ones_nxt = ones_r;
    if (do_wr) begin
      ones_nxt = val_r ? (ones_r + spb_pkg::COUNT_W'(1)) : (ones_r - spb_pkg::COUNT_W'(1));
    end
  end

  // Page word memory write.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_wr) begin
      mem[{slot_r, widx_r}] <= new_word;
    end
  end

  // Tags are written when a slot is claimed.
  always_ff @(posedge clk) begin
    if (cmd.commit && alloc) begin
      tag_r[slot_r] <= page_r;
    end
  end

  // Slot valid bits, word valid bits and the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      wvalid_r <= '0;
      ones_r   <= '0;
    end else if (cmd.commit) begin
      if (alloc) begin
        // A claimed slot starts with only the word being written marked valid.
        valid_r[slot_r]  <= 1'b1;
        wvalid_r[slot_r] <= WPP'(1) << widx_r;
      end else if (do_wr) begin
        wvalid_r[slot_r][widx_r] <= 1'b1;
      end
      ones_r <= ones_nxt;
    end
  end

  // Result fields, registered at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bit_out_r <= old_bit;
      status_r  <= no_page ? spb_pkg::ST_NO_PAGE : spb_pkg::ST_OK;
    end
  end

  assign out_bit_out   = bit_out_r;
  assign out_status    = status_r;
  assign out_set_count = ones_r;

endmodule

[rtl/core/sparse_paged_bitmap_unit.sv]
// Top level of the sparse paged bitmap unit.
//
// Usage: a sparse bitmap over the bit position space, stored in PAGE_SLOTS
// tagged pages. Raise start with in_action, in_position and in_bit_in; the
// operation transfer happens at the clock edge where start is high and busy
// is low. A read returns the bit; a write of one to an absent page claims the
// lowest free page slot, which reads as all zero when claimed.
// The result shows on out_bit_out, out_status and out_set_count, marked by
// out_valid, for exactly one cycle, after the operation registers (loaded at
// the transfer) and then the result registers are loaded. No new operation
// is taken while busy is high; the tag compare and page word read happen at
// the transfer, the page word read-modify-write and the count update in
// the update state. out_status flags a write of one that found no free
// page slot; nothing then changes. out_set_count always holds the number
// of set bits. Reset (rst_n low, synchronous) invalidates every page slot
// and word and clears the count; no memory sweep is needed, so the block
// is ready as soon as reset is released. The receiver cannot stall: each
// result transfer completes in its strobe cycle.
module sparse_paged_bitmap_unit #(
  parameter int unsigned PAGE_SLOTS    = 16,
  parameter int unsigned BITS_PER_PAGE = 1024,
  parameter int unsigned BITS_PER_WORD = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [spb_pkg::POS_W-1:0]   in_position,
  input  logic                        in_bit_in,
  output logic                        out_valid,
  output logic                        out_bit_out,
  output logic                        out_status,
  output logic [spb_pkg::COUNT_W-1:0] out_set_count
);

  spb_pkg::dp_cmd_t cmd;

  // Sequencing.
  spb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Storage and update logic.
  spb_dpath #(
    .PAGE_SLOTS    (PAGE_SLOTS),
    .BITS_PER_PAGE (BITS_PER_PAGE),
    .BITS_PER_WORD (BITS_PER_WORD),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_bit_in     (in_bit_in),
    .out_bit_out   (out_bit_out),
    .out_status    (out_status),
    .out_set_count (out_set_count)
  );

endmodule

[rtl/core/spb_checker.sv]
// Port-level checker for the sparse paged bitmap unit, with its bind.
module spb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_action,
  input logic                        out_valid,
  input logic                        out_status,
  input logic [spb_pkg::COUNT_W-1:0] out_set_count
);

  // An operation transfer starts exactly one busy cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not follow an operation transfer");

  // The busy cycle is a single cycle and is followed by the result strobe.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("result strobe did not follow the busy cycle");

  // A result strobe only appears after a busy cycle.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result strobe without an operation");

  // A read reports ok and leaves the set-bit count alone.
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && (in_action == spb_pkg::ACT_READ), 2))
    |-> ((out_status == spb_pkg::ST_OK) && (out_set_count == $past(out_set_count, 2))))
    else $error("read changed the count or flagged a status");

endmodule

bind sparse_paged_bitmap_unit spb_checker u_spb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_set_count (out_set_count)
);

[verif/testbench.sv]
// Self-checking testbench for the sparse paged bitmap unit.
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int PAGE_SLOTS     = 16;
  localparam int PAGE_BITS      = 1024;
  localparam int OFFSET_W       = $clog2(PAGE_BITS);
  localparam int TAG_W          = spb_pkg::POS_W - OFFSET_W;
  localparam int RANDOM_OPS     = 500;
  localparam int PAGE_POOL      = 24;
  localparam int OFFSET_POOL    = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  // One result transfer as the block reports it.
  typedef struct packed {
    logic                        bit_out;
    logic                        status;
    logic [spb_pkg::COUNT_W-1:0] set_count;
  } result_t;

  // One row of the directed table: the operation and, where typed in, its result.
  typedef struct packed {
    logic                      act;
    logic [spb_pkg::POS_W-1:0] pos;
    logic                      val;
    logic                      typed;
    result_t                   res;
  } bitmap_op_t;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        start         = 1'b0;
  logic                        busy;
  logic                        in_action     = spb_pkg::ACT_READ;
  logic [spb_pkg::POS_W-1:0]   in_position   = '0;
  logic                        in_bit_in     = 1'b0;
  logic                        out_valid;
  logic                        out_bit_out;
  logic                        out_status;
  logic [spb_pkg::COUNT_W-1:0] out_set_count;

  // Typed-in expectation that travels with the operation on the input ports.
  logic               drv_typed     = 1'b0;
  result_t            drv_typed_res = '0;

  // Shadow copy of the bitmap state.
  logic [TAG_W-1:0]            slot_page  [PAGE_SLOTS];
  logic                        slot_valid [PAGE_SLOTS];
  logic [PAGE_BITS-1:0]        slot_bits  [PAGE_SLOTS];
  logic [spb_pkg::COUNT_W-1:0] ones_count;

  result_t pending_results [$];
  int      mismatches  = 0;
  int      idle_cycles = 0;

  sparse_paged_bitmap_unit #(
    .PAGE_SLOTS   (PAGE_SLOTS),
    .BITS_PER_PAGE(PAGE_BITS),
    .BITS_PER_WORD(64),
    .POSITION_BITS(spb_pkg::POS_W)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_position  (in_position),
    .in_bit_in    (in_bit_in),
    .out_valid    (out_valid),
    .out_bit_out  (out_bit_out),
    .out_status   (out_status),
    .out_set_count(out_set_count)
  );

  always #CLK_HALF clk = ~clk;

  // Applies one operation to the shadow bitmap and returns the result it should give.
  function automatic result_t bitmap_apply(input logic act,
                                           input logic [spb_pkg::POS_W-1:0] pos,
                                           input logic val);
    logic [TAG_W-1:0]    page_no;
    logic [OFFSET_W-1:0] offset;
    int                  slot;
    int                  spare;
    result_t             res;
    page_no = pos[spb_pkg::POS_W-1:OFFSET_W];
    offset  = pos[OFFSET_W-1:0];
    slot    = -1;
    spare   = -1;
    // Scan downward so that the lowest matching and lowest free slots win.
    for (int s = PAGE_SLOTS - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_page[s] == page_no) slot = s;
      if (!slot_valid[s]) spare = s;
    end
    res.bit_out = (slot >= 0) ? slot_bits[slot][offset] : 1'b0;
    res.status  = spb_pkg::ST_OK;
    if (act == spb_pkg::ACT_WRITE) begin
      // Only a write of one claims a page; without a free slot it is dropped.
      if (slot < 0 && val) begin
        if (spare < 0) begin
          res.status = spb_pkg::ST_NO_PAGE;
        end else begin
          slot_bits[spare]  = '0;
          slot_page[spare]  = page_no;
          slot_valid[spare] = 1'b1;
          slot              = spare;
        end
      end
      if (slot >= 0 && res.bit_out != val) begin
        slot_bits[slot][offset] = val;
        if (val) ones_count = ones_count + spb_pkg::COUNT_W'(1);
        else ones_count = ones_count - spb_pkg::COUNT_W'(1);
      end
    end
    res.set_count = ones_count;
    return res;
  endfunction

  function automatic bitmap_op_t table_row(input logic act,
                                           input logic [spb_pkg::POS_W-1:0] pos,
                                           input logic val, input logic typed,
                                           input logic bit_out, input logic status,
                                           input int count);
    bitmap_op_t row;
    row.act           = act;
    row.pos           = pos;
    row.val           = val;
    row.typed         = typed;
    row.res.bit_out   = bit_out;
    row.res.status    = status;
    row.res.set_count = spb_pkg::COUNT_W'(count);
    return row;
  endfunction

  // Presents one operation and holds it until the transfer happens.
  task automatic issue_op(input bitmap_op_t op);
    start         <= 1'b1;
    in_action     <= op.act;
    in_position   <= op.pos;
    in_bit_in     <= op.val;
    drv_typed     <= op.typed;
    drv_typed_res <= op.res;
    do @(posedge clk); while (busy);
  endtask

  // Lowers start and waits until every pending result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checking, operation capture and the watchdog share one process.
  always @(posedge clk) begin
    result_t wanted;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending: bit_out=%0b status=%0b set_count=%0d",
                   $time, out_bit_out, out_status, out_set_count);
          mismatches++;
        end else begin
          wanted = pending_results.pop_front();
          if (out_bit_out !== wanted.bit_out) begin
            $display("%0t: bit_out expected %0b actual %0b", $time, wanted.bit_out, out_bit_out);
            mismatches++;
          end
          if (out_status !== wanted.status) begin
            $display("%0t: status expected %0b actual %0b", $time, wanted.status, out_status);
            mismatches++;
          end
          if (out_set_count !== wanted.set_count) begin
            $display("%0t: set_count expected %0d actual %0d", $time, wanted.set_count,
                     out_set_count);
            mismatches++;
          end
        end
      end
      // An operation transfer: predict now, and prefer a typed-in result if given.
      if (start && !busy) begin
        wanted = bitmap_apply(in_action, in_position, in_bit_in);
        pending_results.push_back(drv_typed ? drv_typed_res : wanted);
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time,
                 pending_results.size());
        $display("** sparse_paged_bitmap_unit: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus: a directed table, then random operations in bursts.
  initial begin
    bitmap_op_t          directed_ops [17];
    bitmap_op_t          op;
    logic [TAG_W-1:0]    page_pool [PAGE_POOL];
    logic [OFFSET_W-1:0] offset_pool [OFFSET_POOL];
    logic [OFFSET_W-1:0] offset;
    int                  burst_left;
    int                  gap;

    for (int s = 0; s < PAGE_SLOTS; s++) begin
      slot_valid[s] = 1'b0;
      slot_page[s]  = '0;
      slot_bits[s]  = '0;
    end
    ones_count = '0;

    // Extreme pages and word boundaries, plus random ones, so pages collide often.
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < PAGE_POOL; i++) page_pool[i] = TAG_W'($urandom());
    offset_pool[0] = '0;
    offset_pool[1] = '1;
    offset_pool[2] = OFFSET_W'(63);
    offset_pool[3] = OFFSET_W'(64);
    for (int i = 4; i < OFFSET_POOL; i++) offset_pool[i] = OFFSET_W'($urandom());

    directed_ops = '{
      // Reads and a zero write on an empty bitmap; bit_in is ignored on a read.
      table_row(spb_pkg::ACT_READ,  32'h0000_0000, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 0),
      table_row(spb_pkg::ACT_READ,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, spb_pkg::ST_OK, 0),
      table_row(spb_pkg::ACT_WRITE, 32'h0000_0005, 1'b0, 1'b1, 1'b0, spb_pkg::ST_OK, 0),
      // First page claim, then a write of the value already held.
      table_row(spb_pkg::ACT_WRITE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 1),
      table_row(spb_pkg::ACT_WRITE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, spb_pkg::ST_OK, 1),
      table_row(spb_pkg::ACT_READ,  32'h0000_0000, 1'b0, 1'b1, 1'b1, spb_pkg::ST_OK, 1),
      // Top of the position space lands in its own page.
      table_row(spb_pkg::ACT_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 2),
      table_row(spb_pkg::ACT_READ,  32'h0000_03FF, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 2),
      table_row(spb_pkg::ACT_WRITE, 32'h0000_03FF, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 3),
      // Clearing a set bit, then clearing it again.
      table_row(spb_pkg::ACT_WRITE, 32'h0000_0000, 1'b0, 1'b1, 1'b1, spb_pkg::ST_OK, 2),
      table_row(spb_pkg::ACT_WRITE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, spb_pkg::ST_OK, 2),
      table_row(spb_pkg::ACT_READ,  32'hFFFF_FC00, 1'b0, 1'b1, 1'b0, spb_pkg::ST_OK, 2),
      table_row(spb_pkg::ACT_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, spb_pkg::ST_OK, 1),
      // The page stays claimed after its last bit is cleared.
      table_row(spb_pkg::ACT_READ,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, spb_pkg::ST_OK, 1),
      table_row(spb_pkg::ACT_WRITE, 32'h8000_0040, 1'b1, 1'b0, 1'b0, spb_pkg::ST_OK, 0),
      table_row(spb_pkg::ACT_READ,  32'h8000_0040, 1'b0, 1'b0, 1'b0, spb_pkg::ST_OK, 0),
      table_row(spb_pkg::ACT_WRITE, 32'h7FFF_FFC0, 1'b1, 1'b0, 1'b0, spb_pkg::ST_OK, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, back to back.
    foreach (directed_ops[i]) issue_op(directed_ops[i]);
    drain_results();

    // Random part: mostly pooled pages and offsets so bits get set, read and cleared,
    // and the slots fill up so that writes of one start to be refused.
    burst_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if ($urandom_range(0, 19) == 0) begin
          drain_results();
        end else if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      op.act = ($urandom_range(0, 9) < 4) ? spb_pkg::ACT_READ : spb_pkg::ACT_WRITE;
      op.val = ($urandom_range(0, 99) < 55);
      if ($urandom_range(0, 9) == 0) begin
        op.pos = $urandom();
      end else begin
        offset = ($urandom_range(0, 2) == 0) ? OFFSET_W'($urandom_range(0, PAGE_BITS - 1))
                                             : offset_pool[$urandom_range(0, OFFSET_POOL - 1)];
        op.pos = {page_pool[$urandom_range(0, PAGE_POOL - 1)], offset};
      end
      op.typed = 1'b0;
      op.res   = '0;
      issue_op(op);
    end

    // Let the last results arrive, then wait on for stray strobes.
    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sparse_paged_bitmap_unit: PASSED **");
    end else begin
      $display("** sparse_paged_bitmap_unit: FAILED **");
    end
    $finish;
  end

endmodule
